/* rtl/core/sdbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbc_pkg
// Shared types and constants of the source delimiter balance checker.
// ----------------------------------------------------------------------------
package sdbc_pkg;

	typedef logic [2:0] kind_t;
	typedef logic [2:0] event_t;

	localparam kind_t KIND_PAREN   = 3'd0;
	localparam kind_t KIND_BRACE   = 3'd1;
	localparam kind_t KIND_BRACKET = 3'd2;
	localparam kind_t KIND_DQUOTE  = 3'd3;
	localparam kind_t KIND_SQUOTE  = 3'd4;
	localparam kind_t KIND_BLOCK   = 3'd5;
	localparam kind_t KIND_LINE    = 3'd6;
	localparam kind_t KIND_NONE    = 3'd7;

	localparam event_t EV_PAIR      = 3'd0;
	localparam event_t EV_STRAY     = 3'd1;
	localparam event_t EV_UNCLOSED  = 3'd2;
	localparam event_t EV_NO_REPORT = 3'd3;
	localparam event_t EV_OVERFLOW  = 3'd4;

	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_SQUOTE   = 8'h27;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

endpackage

/* rtl/core/sdbc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/source_delimiter_balance_checker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_delimiter_balance_checker_top
// Scans source text one byte per item, tracks open delimiters on a stack and
// reports matched pairs, stray closers, overflow and the final verdict.
// Throughput: one item per cycle unless m_tready stalls the output; the item
// marked last steps through held byte, last byte and end report, with one
// stack top update per cycle.
// The top two stack entries live in registers, the rest in a RAM whose
// registered read keeps the third entry ready.
// Reset: asynchronous; stack empty, line 1, no clearing pass over the RAM.
// ----------------------------------------------------------------------------
module source_delimiter_balance_checker_top import sdbc_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // text_byte
	input  logic                                s_tlast,  // last_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// symbol_kind[2:0], line_number[LINE_BITS+2:3], is_balanced, zero fill
	output logic [((LINE_BITS+11)/8)*8-1:0]     m_tdata,
	output logic [2:0]                          m_tuser,  // event_kind
	output logic                                m_tlast   // final_result
);

	localparam int AW        = $clog2(STACK_DEPTH);
	localparam int CW        = $clog2(STACK_DEPTH + 1);
	localparam int RAM_DEPTH = 1 << AW;
	localparam int DATA_W    = ((LINE_BITS + 11) / 8) * 8;
	localparam int ENT_W     = LINE_BITS + 3;

	typedef enum logic [1:0] {
		PH_MAIN,
		PH_TAIL,
		PH_END
	} phase_t;

	typedef struct packed {
		logic                 eat;
		logic                 push;
		logic                 pop;
		logic                 fail;
		logic                 line_inc;
		logic                 emit;
		event_t               ev;
		kind_t                kind;
		logic [LINE_BITS-1:0] line;
	} handle_res_t;

	phase_t               phase_q;
	logic                 item_valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	logic [7:0]           held_byte_q;
	logic                 held_valid_q;
	logic [CW-1:0]        count_q;
	logic [LINE_BITS-1:0] line_q;
	logic                 failed_q;
	kind_t                top_kind_q;
	logic [LINE_BITS-1:0] top_line_q;
	kind_t                below_kind_q;
	logic [LINE_BITS-1:0] below_line_q;

	logic                 out_valid_q;
	event_t               out_ev_q;
	kind_t                out_kind_q;
	logic [LINE_BITS-1:0] out_line_q;
	logic                 out_bal_q;
	logic                 out_final_q;

	logic                 can_go;
	logic                 step;
	logic                 item_done;
	logic                 act;
	logic                 la_v;
	logic                 slash_pair;
	logic                 star_close;
	logic                 op_v;
	kind_t                op_k;
	logic                 cl_v;
	kind_t                cl_k;
	kind_t                tk;
	logic                 tk_quote;
	handle_res_t          hr;
	logic [CW-1:0]        count_d;
	logic [CW-1:0]        rd_full;
	logic [ENT_W-1:0]     rd_data;
	logic                 end_line_top;
	logic                 end_v;
	kind_t                end_kind;
	logic [LINE_BITS-1:0] end_line;

	assign can_go    = !out_valid_q || m_tready;
	assign step      = item_valid_s1 && can_go;
	assign item_done = step && (!last_s1 || phase_q == PH_END);
	assign s_tready  = !item_valid_s1 || item_done;
	assign act       = step && phase_q != PH_END && !failed_q && held_valid_q;

	always_comb begin
		la_v       = (phase_q == PH_MAIN);
		slash_pair = held_byte_q == CH_SLASH && la_v && (byte_s1 == CH_STAR || byte_s1 == CH_SLASH);
		star_close = held_byte_q == CH_STAR && la_v && byte_s1 == CH_SLASH;
		op_v = 1'b0;
		op_k = KIND_PAREN;
		cl_v = 1'b0;
		cl_k = KIND_PAREN;
		if (slash_pair) begin
			op_v = 1'b1;
			op_k = (byte_s1 == CH_STAR) ? KIND_BLOCK : KIND_LINE;
		end else if (star_close) begin
			cl_v = 1'b1;
			cl_k = KIND_BLOCK;
		end else begin
			case (held_byte_q)
				CH_DQUOTE: begin
					op_v = 1'b1; op_k = KIND_DQUOTE; cl_v = 1'b1; cl_k = KIND_DQUOTE;
				end
				CH_SQUOTE: begin
					op_v = 1'b1; op_k = KIND_SQUOTE; cl_v = 1'b1; cl_k = KIND_SQUOTE;
				end
				CH_LPAREN:   begin op_v = 1'b1; op_k = KIND_PAREN;   end
				CH_LBRACE:   begin op_v = 1'b1; op_k = KIND_BRACE;   end
				CH_LBRACKET: begin op_v = 1'b1; op_k = KIND_BRACKET; end
				CH_RPAREN:   begin cl_v = 1'b1; cl_k = KIND_PAREN;   end
				CH_RBRACE:   begin cl_v = 1'b1; cl_k = KIND_BRACE;   end
				CH_RBRACKET: begin cl_v = 1'b1; cl_k = KIND_BRACKET; end
				default: ;
			endcase
		end

		tk       = (count_q != '0) ? top_kind_q : KIND_NONE;
		tk_quote = (tk == KIND_DQUOTE) || (tk == KIND_SQUOTE);

		hr      = '0;
		hr.eat  = slash_pair || star_close;
		hr.ev   = EV_PAIR;
		hr.kind = tk;
		hr.line = top_line_q;
		if (tk == KIND_LINE) begin
			if (held_byte_q == CH_NL) begin
				hr.pop = 1'b1;
			end
		end else if (tk == KIND_BLOCK) begin
			if (cl_v && cl_k == KIND_BLOCK) begin
				hr.pop  = 1'b1;
				hr.emit = 1'b1;
			end
		end else if (tk_quote) begin
			if (held_byte_q == CH_BSLASH) begin
				if (la_v) begin
					hr.eat = 1'b1;
					if (byte_s1 == CH_NL) begin
						hr.line_inc = 1'b1;
					end
				end
			end else if (cl_v && cl_k == tk) begin
				hr.pop  = 1'b1;
				hr.emit = 1'b1;
			end
		end else if (op_v) begin
			if (count_q >= CW'(STACK_DEPTH)) begin
				hr.fail = 1'b1;
				hr.emit = 1'b1;
				hr.ev   = EV_OVERFLOW;
				hr.kind = op_k;
				hr.line = line_q;
			end else begin
				hr.push = 1'b1;
				hr.kind = op_k;
				hr.line = line_q;
			end
		end else if (cl_v) begin
			if (tk == cl_k) begin
				hr.pop  = 1'b1;
				hr.emit = 1'b1;
			end else begin
				hr.fail = 1'b1;
				hr.emit = 1'b1;
				hr.ev   = EV_STRAY;
				hr.kind = cl_k;
				hr.line = line_q;
			end
		end
		if (held_byte_q == CH_NL) begin
			hr.line_inc = 1'b1;
			if (tk_quote) begin
				hr.fail = 1'b1;
			end
		end
	end

	always_comb begin
		end_line_top = (count_q != '0) && top_kind_q == KIND_LINE;
		if (end_line_top) begin
			end_v    = count_q >= CW'(2);
			end_kind = below_kind_q;
			end_line = below_line_q;
		end else begin
			end_v    = count_q != '0;
			end_kind = top_kind_q;
			end_line = top_line_q;
		end
	end

	always_comb begin
		count_d = count_q;
		if (step && phase_q == PH_END) begin
			count_d = '0;
		end else if (act && hr.push) begin
			count_d = count_q + CW'(1);
		end else if (act && hr.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	assign rd_full = count_d - CW'(3);

	sdbc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RAM_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (act && hr.push),
		.waddr (count_q[AW-1:0]),
		.wdata ({hr.kind, hr.line}),
		.raddr (rd_full[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (act && hr.push) begin
			top_kind_q   <= hr.kind;
			top_line_q   <= hr.line;
			below_kind_q <= top_kind_q;
			below_line_q <= top_line_q;
		end else if (act && hr.pop) begin
			top_kind_q   <= below_kind_q;
			top_line_q   <= below_line_q;
			below_kind_q <= rd_data[ENT_W-1:LINE_BITS];
			below_line_q <= rd_data[LINE_BITS-1:0];
		end
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (can_go && step) begin
			if (phase_q == PH_END) begin
				out_ev_q    <= end_v ? EV_UNCLOSED : EV_NO_REPORT;
				out_kind_q  <= end_v ? end_kind : KIND_PAREN;
				out_line_q  <= end_v ? end_line : '0;
				out_bal_q   <= !end_v && !failed_q;
				out_final_q <= 1'b1;
			end else begin
				out_ev_q    <= hr.ev;
				out_kind_q  <= hr.kind;
				out_line_q  <= hr.line;
				out_bal_q   <= (hr.ev == EV_PAIR);
				out_final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MAIN;
			item_valid_s1 <= 1'b0;
			held_byte_q   <= '0;
			held_valid_q  <= 1'b0;
			count_q       <= '0;
			line_q        <= LINE_BITS'(1);
			failed_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				item_valid_s1 <= 1'b1;
			end else if (item_done) begin
				item_valid_s1 <= 1'b0;
			end
			if (can_go) begin
				out_valid_q <= step && (phase_q == PH_END || (act && hr.emit));
			end
			count_q <= count_d;
			if (act) begin
				if (hr.fail) begin
					failed_q <= 1'b1;
				end
				if (hr.line_inc && line_q != '1) begin
					line_q <= line_q + LINE_BITS'(1);
				end
			end
			if (step) begin
				unique case (phase_q)
					PH_MAIN: begin
						if (!failed_q) begin
							if (held_valid_q) begin
								if (hr.fail || hr.eat) begin
									held_valid_q <= 1'b0;
								end else begin
									held_byte_q <= byte_s1;
								end
							end else begin
								held_byte_q  <= byte_s1;
								held_valid_q <= 1'b1;
							end
						end
						phase_q <= last_s1 ? PH_TAIL : PH_MAIN;
					end
					PH_TAIL: begin
						held_valid_q <= 1'b0;
						phase_q      <= PH_END;
					end
					PH_END: begin
						held_byte_q  <= '0;
						held_valid_q <= 1'b0;
						line_q       <= LINE_BITS'(1);
						failed_q     <= 1'b0;
						phase_q      <= PH_MAIN;
					end
					default: phase_q <= PH_MAIN;
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_final_q;
	assign m_tdata  = DATA_W'({out_bal_q, out_line_q, out_kind_q});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_no_held_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		!(failed_q && held_valid_q))
		else $error("held byte kept after failure");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_END |=> count_q == '0 && line_q == LINE_BITS'(1) && !failed_q)
		else $error("state not cleared after end report");

	a_fail_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_ev_q == EV_STRAY || out_ev_q == EV_OVERFLOW ||
		out_ev_q == EV_UNCLOSED) |-> !out_bal_q)
		else $error("failure event reported as balanced");

endmodule

/* test/source_delimiter_balance_checker_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_delimiter_balance_checker_top_tb
// Streams short source texts into the checker and predicts every report:
// matched pairs, stray closers, overflow and the end verdict. Each accepted
// text byte is run through a local copy of the scanner state (lookahead byte,
// delimiter stack, line count, failure flag), and each result is compared
// with the oldest predicted report. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module source_delimiter_balance_checker_top_tb;
	import sdbc_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int LINE_BITS   = 16;
	localparam int DATA_W      = ((LINE_BITS + 11) / 8) * 8;
	localparam int STALL_LIMIT = 2000;
	localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
	localparam logic [7:0] CH_X = 8'h78;

	typedef struct {
		event_t                event_kind;
		kind_t                 symbol_kind;
		logic [LINE_BITS-1:0]  line_number;
		logic                  is_balanced;
		logic                  final_result;
	} report_t;

	class balance_tracker;
		logic [7:0]           held;
		bit                   held_ok;
		kind_t                kinds [STACK_DEPTH];
		logic [LINE_BITS-1:0] lines [STACK_DEPTH];
		int                   depth;
		logic [LINE_BITS-1:0] line_no;
		bit                   broken;
		int                   burst;
		report_t              due [$];
		int                   errors;
		int                   items_seen;

		function new();
			clear();
			errors = 0;
			items_seen = 0;
		endfunction

		function void clear();
			held = 8'h00;
			held_ok = 1'b0;
			depth = 0;
			line_no = 1;
			broken = 1'b0;
		endfunction

		function kind_t top();
			if (depth == 0) return KIND_NONE;
			return kinds[depth-1];
		endfunction

		function void post_report(event_t ev, kind_t k, logic [LINE_BITS-1:0] ln, bit fin);
			report_t r;
			if (burst >= 3) return;
			r.event_kind = ev;
			r.symbol_kind = k;
			r.line_number = ln;
			r.is_balanced = !broken;
			r.final_result = fin;
			due.push_back(r);
			burst++;
		endfunction

		function void bump_line();
			if (line_no != LINE_TOP) line_no++;
		endfunction

		function void pop_pair();
			post_report(EV_PAIR, top(), lines[depth-1], 1'b0);
			depth--;
		endfunction

		function bit scan(logic [7:0] h, logic [7:0] la, bit la_ok);
			int    opener;
			int    closer;
			bit    eat;
			kind_t t;
			opener = -1;
			closer = -1;
			eat = 1'b0;
			if (h == CH_SLASH && la_ok && (la == CH_STAR || la == CH_SLASH)) begin
				opener = (la == CH_STAR) ? KIND_BLOCK : KIND_LINE;
				eat = 1'b1;
			end else if (h == CH_STAR && la_ok && la == CH_SLASH) begin
				closer = KIND_BLOCK;
				eat = 1'b1;
			end else begin
				case (h)
					CH_DQUOTE: begin
						opener = KIND_DQUOTE;
						closer = KIND_DQUOTE;
					end
					CH_SQUOTE: begin
						opener = KIND_SQUOTE;
						closer = KIND_SQUOTE;
					end
					CH_LPAREN:   opener = KIND_PAREN;
					CH_LBRACE:   opener = KIND_BRACE;
					CH_LBRACKET: opener = KIND_BRACKET;
					CH_RPAREN:   closer = KIND_PAREN;
					CH_RBRACE:   closer = KIND_BRACE;
					CH_RBRACKET: closer = KIND_BRACKET;
					default: ;
				endcase
			end

			t = top();
			if (t == KIND_LINE) begin
				if (h == CH_NL) depth--;
			end else if (t == KIND_BLOCK) begin
				if (closer == KIND_BLOCK) pop_pair();
			end else if (t == KIND_DQUOTE || t == KIND_SQUOTE) begin
				if (h == CH_BSLASH) begin
					if (la_ok) begin
						eat = 1'b1;
						if (la == CH_NL) bump_line();
					end
				end else if (closer >= 0 && closer == t) begin
					pop_pair();
				end
			end else if (opener >= 0) begin
				if (depth >= STACK_DEPTH) begin
					broken = 1'b1;
					post_report(EV_OVERFLOW, kind_t'(opener), line_no, 1'b0);
				end else begin
					kinds[depth] = kind_t'(opener);
					lines[depth] = line_no;
					depth++;
				end
			end else if (closer >= 0) begin
				if (t != KIND_NONE && closer == t) begin
					pop_pair();
				end else begin
					broken = 1'b1;
					post_report(EV_STRAY, kind_t'(closer), line_no, 1'b0);
				end
			end

			if (h == CH_NL) begin
				t = top();
				if (t == KIND_DQUOTE || t == KIND_SQUOTE) broken = 1'b1;
				bump_line();
			end
			return eat;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			bit    eat;
			kind_t t;
			burst = 0;
			items_seen++;
			if (!broken) begin
				if (held_ok) begin
					eat = scan(held, b, 1'b1);
					if (broken || eat) held_ok = 1'b0;
					else held = b;
				end else begin
					held = b;
					held_ok = 1'b1;
				end
				if (last && !broken && held_ok) begin
					held_ok = 1'b0;
					void'(scan(held, 8'h00, 1'b0));
				end
			end
			if (broken) held_ok = 1'b0;
			if (last) begin
				if (top() == KIND_LINE) depth--;
				t = top();
				if (t != KIND_NONE) begin
					broken = 1'b1;
					post_report(EV_UNCLOSED, t, lines[depth-1], 1'b1);
				end else begin
					post_report(EV_NO_REPORT, KIND_PAREN, '0, 1'b1);
				end
				clear();
			end
		endfunction

		function void match_report(event_t ev, logic [DATA_W-1:0] word, logic fin);
			report_t want;
			if (due.size() == 0) begin
				$error("unexpected result: event_kind %0d data %h", ev, word);
				errors++;
				return;
			end
			want = due.pop_front();
			if (ev !== want.event_kind) begin
				$error("event_kind expected %0d actual %0d", want.event_kind, ev);
				errors++;
			end
			if (word[2:0] !== want.symbol_kind) begin
				$error("symbol_kind expected %0d actual %0d", want.symbol_kind, word[2:0]);
				errors++;
			end
			if (word[LINE_BITS+2:3] !== want.line_number) begin
				$error("line_number expected %0d actual %0d",
					want.line_number, word[LINE_BITS+2:3]);
				errors++;
			end
			if (word[LINE_BITS+3] !== want.is_balanced) begin
				$error("is_balanced expected %0d actual %0d",
					want.is_balanced, word[LINE_BITS+3]);
				errors++;
			end
			if (word[DATA_W-1:LINE_BITS+4] !== '0) begin
				$error("zero fill expected 0 actual %h", word[DATA_W-1:LINE_BITS+4]);
				errors++;
			end
			if (fin !== want.final_result) begin
				$error("final_result expected %0d actual %0d", want.final_result, fin);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic [2:0]        m_tuser;
	logic              m_tlast;

	balance_tracker book = new();
	logic [7:0]     script [$];
	int             idle_odds;
	int             hold_left;
	int             quiet_cycles;

	source_delimiter_balance_checker_top #(
		.STACK_DEPTH(STACK_DEPTH),
		.LINE_BITS  (LINE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) book.match_report(m_tuser, m_tdata, m_tlast);
		if (idle_odds != 0 && hold_left == 0 && $urandom_range(1, idle_odds) == 1)
			hold_left = $urandom_range(1, 8);
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("source_delimiter_balance_checker_top_tb: errors");
			$finish;
		end
	end

	function automatic logic [7:0] opener_of(kind_t k);
		case (k)
			KIND_PAREN: return CH_LPAREN;
			KIND_BRACE: return CH_LBRACE;
			default:    return CH_LBRACKET;
		endcase
	endfunction

	function automatic logic [7:0] closer_of(kind_t k);
		case (k)
			KIND_PAREN: return CH_RPAREN;
			KIND_BRACE: return CH_RBRACE;
			default:    return CH_RBRACKET;
		endcase
	endfunction

	function automatic logic [7:0] letter();
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		book.take_byte(b, last);
	endtask

	task automatic feed_text();
		foreach (script[i]) push_byte(script[i], i == script.size() - 1);
	endtask

	task automatic compose_text(input int span);
		kind_t      nest [$];
		kind_t      k;
		logic [7:0] q;
		int         pick;
		script.delete();
		while (script.size() < span) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				k = kind_t'($urandom_range(KIND_PAREN, KIND_BRACKET));
				nest.push_back(k);
				script.push_back(opener_of(k));
			end else if (pick < 50 && nest.size() > 0) begin
				script.push_back(closer_of(nest.pop_back()));
			end else if (pick < 58) begin
				q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
				script.push_back(q);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 9))
						0: begin
							script.push_back(CH_BSLASH);
							script.push_back(8'($urandom_range(0, 255)));
						end
						1:       script.push_back(8'($urandom_range(0, 255)));
						default: script.push_back(letter());
					endcase
				end
				script.push_back(q);
			end else if (pick < 64) begin
				script.push_back(CH_SLASH);
				script.push_back(CH_STAR);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 5))
						0:       script.push_back(CH_NL);
						1:       script.push_back(CH_STAR);
						2:       script.push_back(CH_RPAREN);
						default: script.push_back(letter());
					endcase
				end
				script.push_back(CH_STAR);
				script.push_back(CH_SLASH);
			end else if (pick < 69) begin
				script.push_back(CH_SLASH);
				script.push_back(CH_SLASH);
				repeat ($urandom_range(0, 3)) script.push_back(letter());
				script.push_back(CH_NL);
			end else if (pick < 80) begin
				script.push_back(CH_NL);
			end else if (pick < 92) begin
				script.push_back(letter());
			end else begin
				script.push_back(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 3) != 0)
			while (nest.size() > 0) script.push_back(closer_of(nest.pop_back()));
		if (script.size() == 0) script.push_back(letter());
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 2))
			0:       idle_odds = 0;
			1:       idle_odds = 3;
			default: idle_odds = 7;
		endcase
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tlast   <= 1'b0;
		m_tready  <= 1'b0;
		idle_odds = 4;
		hold_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// nested pairs, then end with nothing open
		script = '{CH_LBRACE, CH_LBRACKET, CH_LPAREN, 8'h00, CH_RPAREN, CH_RBRACKET,
			CH_RBRACE};
		feed_text();
		// escaped quote, top byte, escaped newline inside single quotes
		script = '{CH_DQUOTE, CH_BSLASH, CH_DQUOTE, 8'hFF, CH_DQUOTE,
			CH_SQUOTE, CH_BSLASH, CH_NL, CH_SQUOTE};
		feed_text();
		// block comment hiding a closer, line comment open at the end
		script = '{CH_SLASH, CH_STAR, CH_RPAREN, CH_STAR, CH_SLASH, CH_SLASH, CH_SLASH, CH_X};
		feed_text();
		// stray star-slash
		script = '{CH_STAR, CH_SLASH};
		feed_text();
		// stray paren as a lone last byte
		script = '{CH_RPAREN};
		feed_text();
		// newline inside a quote, trailing bytes dropped
		script = '{CH_SQUOTE, CH_NL, CH_RBRACKET};
		feed_text();
		// backslash as the last byte escapes nothing
		script = '{CH_DQUOTE, CH_BSLASH};
		feed_text();

		while (book.items_seen < 80) begin
			pick_idling();
			compose_text($urandom_range(4, 24));
			feed_text();
		end

		// fill the stack, then push past its top
		idle_odds = 5;
		script.delete();
		repeat (STACK_DEPTH + 2)
			script.push_back(opener_of(kind_t'($urandom_range(KIND_PAREN, KIND_BRACKET))));
		script.push_back(CH_X);
		feed_text();

		idle_odds = 0;
		repeat (2) begin
			compose_text($urandom_range(4, 24));
			feed_text();
		end

		s_tvalid <= 1'b0;
		while (book.due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (book.errors == 0)
			$display("source_delimiter_balance_checker_top_tb: clean");
		else
			$display("source_delimiter_balance_checker_top_tb: errors");
		$finish;
	end

endmodule
